[rtl/core/ltc_pkg.sv]
// shared types and constants of the tile cache
package ltc_pkg;

	localparam int KEY_W = 56;
	localparam int BYTE_W = 40;
	localparam int SIZE_W = 24;
	localparam int HANDLE_W = 16;
	localparam int RESULT_CAP = 32;
	localparam int K_W = $clog2(RESULT_CAP + 1);
	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOOKUP,
		MODE_PROBE,
		MODE_INSERT,
		MODE_SHRINK
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_IGNORED,
		STATUS_FULL,
		STATUS_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EXEC,
		ST_CHECK,
		ST_SCAN,
		ST_EVICT
	} state_t;

	typedef struct packed {
		mode_t mode;
		logic [KEY_W-1:0] key;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0] nbytes;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic [1:0] index;
		logic [BYTE_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic hit;
		logic [HANDLE_W-1:0] found_handle;
		logic evicted;
		logic [2:0] evicted_face;
		logic [4:0] evicted_level;
		logic [23:0] evicted_x;
		logic [23:0] evicted_y;
		logic [HANDLE_W-1:0] evicted_handle;
		status_t status;
		logic [BYTE_W-1:0] bytes_in_use;
		logic last_result;
	} res_t;

endpackage

[rtl/core/ltc_front.sv]
// front end: accepts request words, classifies them and queues them
module ltc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           mode,
	input  logic [2:0]           tile_face,
	input  logic [4:0]           tile_level,
	input  logic [23:0]          tile_x,
	input  logic [23:0]          tile_y,
	input  logic [15:0]          image_handle,
	input  logic [23:0]          image_bytes,
	output ltc_pkg::cmd_t        cq_data,
	output logic                 cq_empty,
	input  logic                 cq_pop
);

	ltc_pkg::cmd_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;
	ltc_pkg::cmd_t cmd_in;

	// classify and pack the incoming word
	always_comb begin
		cmd_in.mode = ltc_pkg::mode_t'(mode);
		cmd_in.key = {tile_face, tile_level, tile_x, tile_y};
		cmd_in.handle = image_handle;
		cmd_in.nbytes = image_bytes;
	end

	assign full = (count_q == 2'd2);
	assign cq_empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = cq_pop && !cq_empty;
	assign cq_data = slot_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule

[rtl/core/ltc_back.sv]
// back end: slot table, lookup, insert and oldest-first eviction
module ltc_back #(
	parameter int ENTRY_COUNT = 32,
	parameter int STAMP_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltc_pkg::cfg_wr_t     cfg_wr,
	input  ltc_pkg::cmd_t        cq_data,
	input  logic                 cq_empty,
	output logic                 cq_pop,
	output ltc_pkg::res_t        res,
	output logic                 res_empty,
	input  logic                 res_pop
);

	localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int BW = ltc_pkg::BYTE_W;
	localparam int SW = ltc_pkg::SIZE_W;

	// configuration
	logic en_q;
	logic [BW-1:0] limit_q;
	logic [BW-1:0] target_q;

	// slot table
	logic [ENTRY_COUNT-1:0] valid_q;
	logic [ltc_pkg::KEY_W-1:0] key_q [ENTRY_COUNT];
	logic [ltc_pkg::HANDLE_W-1:0] handle_q [ENTRY_COUNT];
	logic [SW-1:0] size_q [ENTRY_COUNT];
	logic [STAMP_BITS-1:0] stamp_q [ENTRY_COUNT];
	logic [STAMP_BITS-1:0] clock_q;
	logic [BW-1:0] total_q;

	// control
	ltc_pkg::state_t state_q, state_d;
	ltc_pkg::cmd_t cmd_q;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] scan_q;
	logic found_q;
	logic [IDX_W-1:0] best_q;
	logic [STAMP_BITS-1:0] best_age_q;
	logic [ltc_pkg::K_W-1:0] k_q;
	ltc_pkg::res_t res_q;
	logic out_valid_q;

	// combinational
	logic match_any, free_any;
	logic [IDX_W-1:0] match_idx, free_idx;
	logic [STAMP_BITS-1:0] scan_age;
	logic [ENTRY_COUNT-1:0] best_oh;
	logic remain_any;
	logic [BW:0] add_sum;
	logic [BW-1:0] add_total, sub_total, evict_size;
	logic out_space;
	logic out_load;
	ltc_pkg::res_t res_d;
	logic do_touch, do_insert, do_evict;
	logic [IDX_W-1:0] touch_idx;
	logic [BW-1:0] new_total;
	logic evict_last;

	// parallel key compare and lowest free slot
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == cmd_q.key) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// age of the scanned slot and the survivors of an eviction
	assign scan_age = clock_q - stamp_q[scan_q];
	always_comb begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			best_oh[i] = (best_q == IDX_W'(i));
		end
	end
	assign remain_any = |(valid_q & ~best_oh);

	// saturating byte arithmetic
	assign add_sum = {1'b0, total_q} + {{(BW - SW + 1){1'b0}}, cmd_q.nbytes};
	assign add_total = add_sum[BW] ? ltc_pkg::BYTE_MAX : add_sum[BW-1:0];
	assign evict_size = {{(BW - SW){1'b0}}, size_q[best_q]};
	assign sub_total = (total_q > evict_size) ? total_q - evict_size : '0;

	assign out_space = !out_valid_q || res_pop;
	assign evict_last = (k_q == ltc_pkg::K_W'(ltc_pkg::RESULT_CAP - 1))
		|| (sub_total <= target_q) || !remain_any;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result assembly
	always_comb begin
		state_d = state_q;
		cq_pop = 1'b0;
		out_load = 1'b0;
		res_d = '0;
		res_d.bytes_in_use = total_q;
		res_d.last_result = 1'b1;
		res_d.status = ltc_pkg::STATUS_OK;
		do_touch = 1'b0;
		do_insert = 1'b0;
		do_evict = 1'b0;
		touch_idx = hit_idx_q;
		new_total = total_q;
		case (state_q)
			ltc_pkg::ST_IDLE: begin
				if (!cq_empty) begin
					cq_pop = 1'b1;
					state_d = ltc_pkg::ST_MATCH;
				end
			end
			ltc_pkg::ST_MATCH: begin
				state_d = (cmd_q.mode == ltc_pkg::MODE_SHRINK) ? ltc_pkg::ST_CHECK
					: ltc_pkg::ST_EXEC;
			end
			ltc_pkg::ST_EXEC: begin
				if (out_space) begin
					out_load = 1'b1;
					state_d = ltc_pkg::ST_IDLE;
					if (cmd_q.mode == ltc_pkg::MODE_INSERT) begin
						if (!en_q || limit_q == '0 || cmd_q.handle == '0) begin
							res_d.status = ltc_pkg::STATUS_IGNORED;
						end else if (hit_q) begin
							do_touch = 1'b1;
							res_d.hit = 1'b1;
							res_d.found_handle = handle_q[hit_idx_q];
						end else if (!free_q) begin
							res_d.status = ltc_pkg::STATUS_FULL;
						end else begin
							do_insert = 1'b1;
							do_touch = 1'b1;
							touch_idx = free_idx_q;
							new_total = add_total;
							res_d.bytes_in_use = add_total;
						end
					end else if (cmd_q.mode == ltc_pkg::MODE_LOOKUP && !en_q) begin
						res_d.status = ltc_pkg::STATUS_IGNORED;
					end else if (hit_q) begin
						do_touch = (cmd_q.mode == ltc_pkg::MODE_LOOKUP);
						res_d.hit = 1'b1;
						res_d.found_handle = handle_q[hit_idx_q];
					end
				end
			end
			ltc_pkg::ST_CHECK: begin
				if (total_q <= target_q) begin
					if (out_space) begin
						out_load = 1'b1;
						state_d = ltc_pkg::ST_IDLE;
					end
				end else if (valid_q == '0) begin
					if (out_space) begin
						out_load = 1'b1;
						res_d.status = ltc_pkg::STATUS_EMPTY;
						state_d = ltc_pkg::ST_IDLE;
					end
				end else begin
					state_d = ltc_pkg::ST_SCAN;
				end
			end
			ltc_pkg::ST_SCAN: begin
				if (scan_q == IDX_W'(ENTRY_COUNT - 1)) state_d = ltc_pkg::ST_EVICT;
			end
			ltc_pkg::ST_EVICT: begin
				if (out_space) begin
					out_load = 1'b1;
					do_evict = 1'b1;
					new_total = sub_total;
					res_d.evicted = 1'b1;
					res_d.evicted_face = key_q[best_q][55:53];
					res_d.evicted_level = key_q[best_q][52:48];
					res_d.evicted_x = key_q[best_q][47:24];
					res_d.evicted_y = key_q[best_q][23:0];
					res_d.evicted_handle = handle_q[best_q];
					res_d.bytes_in_use = sub_total;
					res_d.last_result = evict_last;
					if (k_q != ltc_pkg::K_W'(ltc_pkg::RESULT_CAP - 1)
						&& sub_total > target_q && !remain_any) begin
						res_d.status = ltc_pkg::STATUS_EMPTY;
					end
					state_d = evict_last ? ltc_pkg::ST_IDLE : ltc_pkg::ST_SCAN;
				end
			end
			default: state_d = ltc_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			limit_q <= BW'(64'd16777216);
			target_q <= BW'(64'd8388608);
			valid_q <= '0;
			clock_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			found_q <= 1'b0;
			scan_q <= '0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					ltc_pkg::REG_ENABLE: en_q <= cfg_wr.data[0];
					ltc_pkg::REG_LIMIT:  limit_q <= cfg_wr.data;
					ltc_pkg::REG_TARGET: target_q <= cfg_wr.data;
					default: ;
				endcase
			end
			total_q <= new_total;
			if (do_touch) clock_q <= clock_q + STAMP_BITS'(1);
			if (do_insert) valid_q[free_idx_q] <= 1'b1;
			if (do_evict) begin
				valid_q[best_q] <= 1'b0;
				k_q <= k_q + ltc_pkg::K_W'(1);
			end
			if (cq_pop) k_q <= '0;
			// scan restarts before each eviction search
			if (state_q == ltc_pkg::ST_CHECK || do_evict) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == ltc_pkg::ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
				if (valid_q[scan_q] && (!found_q || scan_age > best_age_q)) found_q <= 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (res_pop) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cq_pop) cmd_q <= cq_data;
		if (state_q == ltc_pkg::ST_MATCH) begin
			hit_q <= match_any;
			hit_idx_q <= match_idx;
			free_q <= free_any;
			free_idx_q <= free_idx;
		end
		if (state_q == ltc_pkg::ST_SCAN && valid_q[scan_q]
			&& (!found_q || scan_age > best_age_q)) begin
			best_q <= scan_q;
			best_age_q <= scan_age;
		end
		if (do_touch) stamp_q[touch_idx] <= clock_q;
		if (do_insert) begin
			key_q[free_idx_q] <= cmd_q.key;
			handle_q[free_idx_q] <= cmd_q.handle;
			size_q[free_idx_q] <= cmd_q.nbytes;
		end
		if (out_load) res_q <= res_d;
	end

	assign res = res_q;
	assign res_empty = !out_valid_q;

endmodule

[rtl/core/lru_tile_cache_byte_budget.sv]
// top level of the tile cache with byte budget
//
//  channel  | handshake          | content
//  ---------+--------------------+---------------------------------------
//  request  | push / full        | mode, tile key, image handle and size
//  result   | empty / pop        | hit, eviction, status, bytes in use
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// lookup, probe and insert pass from queue to result register through take,
// key compare and update; a shrink runs a serial age scan over the slot
// table for the oldest entry before each eviction.
// reset clears slot valid bits, access clock and byte total at once.
// a two-word queue decouples requests; the result register stalls the back end.
module lru_tile_cache_byte_budget #(
	parameter int ENTRY_COUNT = 32,
	parameter int STAMP_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [2:0]  tile_face,
	input  logic [4:0]  tile_level,
	input  logic [23:0] tile_x,
	input  logic [23:0] tile_y,
	input  logic [15:0] image_handle,
	input  logic [23:0] image_bytes,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic [15:0] found_handle,
	output logic        evicted,
	output logic [2:0]  evicted_face,
	output logic [4:0]  evicted_level,
	output logic [23:0] evicted_x,
	output logic [23:0] evicted_y,
	output logic [15:0] evicted_handle,
	output logic [1:0]  status,
	output logic [39:0] bytes_in_use,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	ltc_pkg::cmd_t cq_data;
	logic cq_empty;
	logic cq_pop;
	ltc_pkg::res_t res;
	ltc_pkg::cfg_wr_t cfg_wr;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data = cfg_data;

	ltc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.tile_face    (tile_face),
		.tile_level   (tile_level),
		.tile_x       (tile_x),
		.tile_y       (tile_y),
		.image_handle (image_handle),
		.image_bytes  (image_bytes),
		.cq_data      (cq_data),
		.cq_empty     (cq_empty),
		.cq_pop       (cq_pop)
	);

	ltc_back #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.STAMP_BITS  (STAMP_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cq_data   (cq_data),
		.cq_empty  (cq_empty),
		.cq_pop    (cq_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	// result word onto the ports
	assign hit = res.hit;
	assign found_handle = res.found_handle;
	assign evicted = res.evicted;
	assign evicted_face = res.evicted_face;
	assign evicted_level = res.evicted_level;
	assign evicted_x = res.evicted_x;
	assign evicted_y = res.evicted_y;
	assign evicted_handle = res.evicted_handle;
	assign status = res.status;
	assign bytes_in_use = res.bytes_in_use;
	assign last_result = res.last_result;

endmodule

[rtl/core/ltc_checker.sv]
// port-level checks of the tile cache and their binding
module ltc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        hit,
	input logic [15:0] found_handle,
	input logic        evicted,
	input logic [15:0] evicted_handle,
	input logic [39:0] bytes_in_use,
	input logic        last_result
);

	// a word that is not last always reports an eviction
	a_more_means_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_result) |-> evicted)
		else $error("non-final result without eviction");

	// a hit carries a real handle and no eviction
	a_hit_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hit) |-> (found_handle != 16'd0 && !evicted))
		else $error("hit with zero handle or eviction");

	// the eviction handle is clear when nothing is evicted
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !evicted) |-> (evicted_handle == 16'd0))
		else $error("eviction handle set without eviction");

	// a stalled result word stays valid and holds its byte count and last flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(bytes_in_use) && $stable(last_result)))
		else $error("result word changed while stalled");

endmodule

bind lru_tile_cache_byte_budget ltc_checker u_ltc_checker (.*);
